// ===== hdl/sha1_block_compression_defines.svh =====
// assertion macros shared by the sha1 block compression checker
`ifndef SHA1_BLOCK_COMPRESSION_DEFINES_SVH
`define SHA1_BLOCK_COMPRESSION_DEFINES_SVH

// clocked assertion, switched off while reset is held
`define SHA1BC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked assertion that also covers the reset cycles
`define SHA1BC_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/sha1bc_pkg.sv =====
// shared types and constants of the sha1 block compression engine
package sha1bc_pkg;

    localparam int WORD_W      = 32;
    localparam int CHAIN_WORDS = 5;
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 80;

    typedef logic [WORD_W-1:0] word_t;

    // initial chaining value, h0 at index 0
    localparam word_t [CHAIN_WORDS-1:0] SHA1_IV = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    // round constants, one per group of twenty rounds
    localparam word_t K_ROUND0 = 32'h5A827999;
    localparam word_t K_ROUND1 = 32'h6ED9EBA1;
    localparam word_t K_ROUND2 = 32'h8F1BBCDC;
    localparam word_t K_ROUND3 = 32'hCA62C1D6;

endpackage

// ===== hdl/sha1_block_compression.sv =====
// sha1 block compression: gathers 16 words, runs 80 rounds, emits the chaining value
//
//  channel | ports                      | tdata                  | tuser / tlast
//  --------+----------------------------+------------------------+---------------------------
//  input   | s_tvalid s_tready s_tdata  | [31:0] message_word    | tuser[0] first_of_message
//  result  | m_tvalid m_tready m_tdata  | [31:0] digest_word     | tlast digest_last
//
// words 1 to 15 of a block are only gathered; the 16th starts the 80 rounds
// on the single round adder, then the ST_ADD state adds into the chaining value,
// then five result items follow, one per cycle while m_tready is high. s_tready
// is low from the 16th word until the fifth result is taken. reset reloads the
// initial chaining value and empties the block.
module sha1_block_compression (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  sha1bc_pkg::word_t s_tdata,   // [31:0] message_word
    input  logic              s_tuser,   // [0] first_of_message
    output logic              m_tvalid,
    input  logic              m_tready,
    output sha1bc_pkg::word_t m_tdata,   // [31:0] digest_word
    output logic              m_tlast
);
    import sha1bc_pkg::*;

    localparam int CNT_W = $clog2(BLOCK_WORDS);
    localparam int RND_W = $clog2(ROUNDS);
    localparam int IDX_W = $clog2(CHAIN_WORDS);

    localparam logic [CNT_W-1:0] LAST_WORD  = CNT_W'(BLOCK_WORDS - 1);
    localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUNDS - 1);
    localparam logic [RND_W-1:0] END_PHASE0 = RND_W'(20);
    localparam logic [RND_W-1:0] END_PHASE1 = RND_W'(40);
    localparam logic [RND_W-1:0] END_PHASE2 = RND_W'(60);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(CHAIN_WORDS - 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } state_t;

    state_t                         state_reg,  state_next;
    logic  [CNT_W-1:0]              cnt_reg,    cnt_next;
    logic  [RND_W-1:0]              rnd_reg,    rnd_next;
    logic  [IDX_W-1:0]              idx_reg,    idx_next;
    word_t [CHAIN_WORDS-1:0]        chain_reg,  chain_next;
    word_t [BLOCK_WORDS-1:0]        sched_reg,  sched_next;
    word_t                          a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t                          a_next, b_next, c_next, d_next, e_next;

    logic  s_accept;
    word_t f_val;
    word_t k_val;
    word_t t_val;
    word_t w_new;

    assign s_accept = s_tvalid && s_tready;

    // round function and constant by round group
    always_comb begin
        if (rnd_reg < END_PHASE0) begin
            f_val = d_reg ^ (b_reg & (c_reg ^ d_reg));
            k_val = K_ROUND0;
        end else if (rnd_reg < END_PHASE1) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_ROUND1;
        end else if (rnd_reg < END_PHASE2) begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K_ROUND2;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_ROUND3;
        end
    end

    assign t_val = {a_reg[WORD_W-6:0], a_reg[WORD_W-1:WORD_W-5]}
                   + f_val + e_reg + k_val + sched_reg[0];

    // schedule window: sched_reg[0] is the word of the current round
    always_comb begin
        word_t x;
        x     = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
        w_new = {x[WORD_W-2:0], x[WORD_W-1]};
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        chain_next = chain_reg;
        sched_next = sched_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_accept) begin
                    sched_next = {s_tdata, sched_reg[BLOCK_WORDS-1:1]};
                    if (s_tuser) begin
                        // fresh message: drop gathered words, restart chain
                        chain_next = SHA1_IV;
                        cnt_next   = CNT_W'(1);
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        if (cnt_reg == LAST_WORD) begin
                            state_next = ST_ROUND;
                            rnd_next   = '0;
                            a_next     = chain_reg[0];
                            b_next     = chain_reg[1];
                            c_next     = chain_reg[2];
                            d_next     = chain_reg[3];
                            e_next     = chain_reg[4];
                        end
                    end
                end
            end
            ST_ROUND: begin
                a_next     = t_val;
                b_next     = a_reg;
                c_next     = {b_reg[1:0], b_reg[WORD_W-1:2]};
                d_next     = c_reg;
                e_next     = d_reg;
                sched_next = {w_new, sched_reg[BLOCK_WORDS-1:1]};
                rnd_next   = rnd_reg + RND_W'(1);
                if (rnd_reg == LAST_ROUND) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                chain_next[4] = chain_reg[4] + e_reg;
                idx_next      = '0;
                state_next    = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_tready) begin
                    if (idx_reg == LAST_IDX) begin
                        state_next = ST_LOAD;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            chain_reg <= SHA1_IV;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge aclk) begin
        sched_reg <= sched_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
        e_reg     <= e_next;
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = chain_reg[idx_reg];
    assign m_tlast  = (idx_reg == LAST_IDX);

endmodule

// ===== hdl/sha1bc_checker.sv =====
// port checker for the sha1 block compression engine, bound to the top level
`include "sha1_block_compression_defines.svh"

module sha1bc_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              s_tuser,
    input logic              m_tvalid,
    input logic              m_tready,
    input sha1bc_pkg::word_t m_tdata,
    input logic              m_tlast
);
    logic  s_accept;
    logic  m_accept;

    assign s_accept    = s_tvalid && s_tready;
    assign m_accept    = m_tvalid && m_tready;

    // no item is taken while results of a block are still being sent
    `SHA1BC_ASSERT(a_no_overlap, aclk, aresetn, !(s_tready && m_tvalid), "input ready while results pending")

    // a stalled result holds its word and marker
    `SHA1BC_ASSERT(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)), "stalled result changed")

    // the fifth result hands control back to the input side
    `SHA1BC_ASSERT(a_back_to_load, aclk, aresetn, (m_accept && m_tlast) |=> (s_tready && !m_tvalid), "input not ready after last result")

    // an input item never causes a result in the very next cycle
    `SHA1BC_ASSERT(a_no_instant_out, aclk, aresetn, (s_accept && !s_tuser) |=> !m_tvalid, "result right after an input item")

    // reset leaves the block waiting for input
    `SHA1BC_ASSERT_RST(a_reset_ready, aclk, !aresetn |=> (s_tready && !m_tvalid), "not idle after reset")

endmodule

bind sha1_block_compression sha1bc_checker u_sha1bc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== test/tb.sv =====
// self-checking testbench for the sha1 block compression engine
`timescale 1ns / 100ps

module tb;
    import sha1bc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 120;
    localparam int RANDOM_WORDS = 168;
    localparam int MIN_BLOCKS   = 10;

    typedef struct {
        word_t word;
        logic  first;
        bit    hold;    // wait for every digest item before sending
    } msg_word_t;

    typedef struct {
        word_t word;
        logic  last;
    } digest_item_t;

    logic  aclk     = 1'b0;
    logic  aresetn  = 1'b0;
    logic  s_tvalid = 1'b0;
    logic  s_tready;
    word_t s_tdata  = '0;
    logic  s_tuser  = 1'b0;
    logic  m_tvalid;
    logic  m_tready = 1'b0;
    word_t m_tdata;
    logic  m_tlast;

    sha1_block_compression dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [31:0] message_word
        .s_tuser  (s_tuser),    // [0] first_of_message
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [31:0] digest_word
        .m_tlast  (m_tlast)
    );

    initial forever #6 aclk = ~aclk;

    msg_word_t    pending_words[$];
    digest_item_t digest_q[$];
    int           fail_count = 0;
    int           cycle_count = 0;

    // predictor state
    word_t      chain_h   [CHAIN_WORDS];
    word_t      block_buf [BLOCK_WORDS];
    logic [3:0] fill_count;

    // generator's view of block alignment
    int gen_pos = 0;
    int gen_blocks = 0;

    function automatic word_t rol32(word_t v, int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    function automatic void sha1_compress();
        word_t w [ROUNDS];
        word_t a, b, c, d, e, f, k, t;
        for (int r = 0; r < ROUNDS; r++)
            w[r] = (r < BLOCK_WORDS) ? block_buf[r]
                                     : rol32(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < ROUNDS; r++) begin
            if (r < 20) begin
                f = d ^ (b & (c ^ d));
                k = K_ROUND0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K_ROUND1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_ROUND2;
            end else begin
                f = b ^ c ^ d;
                k = K_ROUND3;
            end
            t = rol32(a, 5) + f + e + k + w[r];
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    function automatic void absorb_message_word(word_t w, logic first);
        digest_item_t item;
        if (first) begin
            for (int i = 0; i < CHAIN_WORDS; i++)
                chain_h[i] = SHA1_IV[i];
            fill_count = '0;
        end
        block_buf[fill_count] = w;
        fill_count++;
        if (fill_count == 0) begin
            sha1_compress();
            for (int i = 0; i < CHAIN_WORDS; i++) begin
                item.word = chain_h[i];
                item.last = (i == CHAIN_WORDS - 1);
                digest_q.push_back(item);
            end
        end
    endfunction

    function automatic void queue_word(word_t w, logic first, bit hold);
        msg_word_t m;
        m.word  = w;
        m.first = first;
        m.hold  = hold;
        pending_words.push_back(m);
        gen_pos = first ? 1 : gen_pos + 1;
        if (gen_pos == BLOCK_WORDS) begin
            gen_pos = 0;
            gen_blocks++;
        end
    endfunction

    function automatic word_t pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // sender
    int s_gap = 0;
    bit s_burst = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_gap <= 0;
        end else begin
            if (s_tvalid && s_tready)
                absorb_message_word(s_tdata, s_tuser);
            if (!s_tvalid || s_tready) begin
                if (s_gap != 0) begin
                    s_tvalid <= 1'b0;
                    s_gap <= s_gap - 1;
                end else if (pending_words.size() != 0 &&
                             (!pending_words[0].hold || digest_q.size() == 0)) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_words[0].word;
                    s_tuser <= pending_words[0].first;
                    void'(pending_words.pop_front());
                    if ($urandom_range(0, 23) == 0)
                        s_burst = !s_burst;
                    s_gap <= s_burst ? 0 : $urandom_range(0, 4);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver
    int m_gap = 0;
    int m_gap_next;
    bit m_burst = 0;
    digest_item_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_gap <= 0;
        end else begin
            m_gap_next = m_gap;
            if (m_tvalid && m_tready) begin
                if (digest_q.size() == 0) begin
                    $error("unexpected digest item: digest_word %h digest_last %b",
                           m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    want = digest_q.pop_front();
                    if (m_tdata !== want.word) begin
                        $error("digest_word: expected %h, got %h", want.word, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("digest_last: expected %b, got %b", want.last, m_tlast);
                        fail_count++;
                    end
                end
                if ($urandom_range(0, 23) == 0)
                    m_burst = !m_burst;
                m_gap_next = m_burst ? 0 : $urandom_range(0, 4);
            end
            if (m_gap_next != 0) begin
                m_tready <= 1'b0;
                m_gap <= m_gap_next - 1;
            end else begin
                m_tready <= 1'b1;
                m_gap <= 0;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int  n;
        int  random_words;
        bit  broken;
        bit  start_first;
        bit  hold;

        for (int i = 0; i < CHAIN_WORDS; i++)
            chain_h[i] = SHA1_IV[i];
        fill_count = '0;

        // partial block of all ones, then abandoned by a restart
        for (int i = 0; i < 4; i++)
            queue_word('1, i == 0, 1'b0);
        // fresh block with the field extremes and single set bits
        for (int i = 0; i < BLOCK_WORDS; i++) begin
            case (i)
                0:       queue_word('0, 1'b1, 1'b0);
                1:       queue_word('1, 1'b0, 1'b0);
                2:       queue_word(32'h8000_0000, 1'b0, 1'b0);
                3:       queue_word(32'h0000_0001, 1'b0, 1'b0);
                default: queue_word((i % 2) ? 32'hAAAA_AAAA : 32'h5555_5555, 1'b0, 1'b0);
            endcase
        end
        // chain continues into a second block, sent only once the digest is out
        for (int i = 0; i < BLOCK_WORDS; i++)
            queue_word((i == 0) ? 32'h6162_6380 : '0, 1'b0, i == 0);

        random_words = 0;
        while (random_words < RANDOM_WORDS || gen_blocks < MIN_BLOCKS) begin
            broken      = ($urandom_range(0, 4) == 0);
            start_first = ($urandom_range(0, 3) != 0);
            hold        = ($urandom_range(0, 5) == 0);
            n = broken ? $urandom_range(1, 15) : BLOCK_WORDS * $urandom_range(1, 2);
            for (int i = 0; i < n; i++) begin
                queue_word(pick_word(), (i == 0) ? start_first : 1'b0,
                           (i == 0) ? hold : 1'b0);
                random_words++;
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        do
            @(negedge aclk);
        while (pending_words.size() != 0 || s_tvalid || digest_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
